FILE: sv/nfsp_pkg.sv
package nfsp_pkg;

  localparam int SIZE_BITS = 16;
  localparam int POS_BITS  = SIZE_BITS + 1;
  localparam int BIN_BITS  = 16;

  localparam int IN_FIELDS_W  = 2 * SIZE_BITS + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * POS_BITS + BIN_BITS + 2;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_BIN_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_HEIGHT = 1'd1;

  localparam logic [SIZE_BITS-1:0] BIN_SIZE_RESET = SIZE_BITS'(1024);

endpackage

FILE: sv/next_fit_shelf_packer_core.sv
// Next-fit shelf packer: places one rectangle per accepted item into equal bins of
// bin_width x bin_height, with one open shelf in the newest bin. Each item gives one
// result (x, y, bin, rotation, oversize). The block takes one item per clock while
// m_tready does not hold the result register: the fit tests, the shelf and bin update
// and the result are one pass of adds and compares between the input register and the
// result register, and the shelf state is written in that same cycle, so the next item
// sees it. bin_width and bin_height must be written by the user over the cfg port only
// while the block is idle; the block itself does not enforce this. Both reset to 1024.
module next_fit_shelf_packer_core (
  input  logic                             clk,
  input  logic                             rst,
  // rect_width, rect_height, allow_rotation, zero pad
  input  logic [nfsp_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pos_x, pos_y, bin_number, was_rotated, oversize, zero pad
  output logic [nfsp_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nfsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nfsp_pkg::SIZE_BITS-1:0]   cfg_data
);
  import nfsp_pkg::*;

  localparam int S = SIZE_BITS;
  localparam int P = POS_BITS;

  // configuration
  logic [S-1:0] bin_width;
  logic [S-1:0] bin_height;

  // shelf state
  logic [P-1:0]        shelf_offset;
  logic [S-1:0]        shelf_height;
  logic [P-1:0]        shelf_used_width;
  logic [BIN_BITS-1:0] current_bin;

  // input register
  logic         in_valid;
  logic [S-1:0] in_w;
  logic [S-1:0] in_h;
  logic         in_rot;

  // result register
  logic                out_valid;
  logic [P-1:0]        out_x;
  logic [P-1:0]        out_y;
  logic [BIN_BITS-1:0] out_bin;
  logic                out_rot;
  logic                out_over;

  logic advance;
  logic in_take;

  // placement logic
  logic [S-1:0]        longside;
  logic                swap1;
  logic                swap2;
  logic [S-1:0]        w1;
  logic [S-1:0]        h1;
  logic [S-1:0]        w2;
  logic [S-1:0]        h2;
  logic                fits;
  logic                fits_above;
  logic [P:0]          stack_sum;
  logic [P-1:0]        stack_sat;
  logic [P-1:0]        base_offset;
  logic [P-1:0]        base_used;
  logic [S-1:0]        base_height;
  logic [P:0]          end_x;
  logic [P:0]          end_y;
  logic [P-1:0]        shelf_offset_next;
  logic [S-1:0]        shelf_height_next;
  logic [P-1:0]        shelf_used_width_next;
  logic [BIN_BITS-1:0] current_bin_next;
  logic                over_next;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign in_take   = s_tvalid && s_tready;

  always_comb begin
    longside = (in_w > in_h) ? in_w : in_h;
    // turn upright when the long side fits under the open shelf, flat otherwise
    swap1 = in_rot && ((in_h > in_w) != (longside <= shelf_height));
    w1 = swap1 ? in_h : in_w;
    h1 = swap1 ? in_w : in_h;

    fits = (({1'b0, shelf_used_width} + {2'b0, w1}) <= {2'b0, bin_width}) &&
           (({1'b0, shelf_offset} + {2'b0, h1}) <= {2'b0, bin_height});
    fits_above = (({2'b0, shelf_offset} + {3'b0, shelf_height} + {3'b0, h1})
                  <= {3'b0, bin_height});

    stack_sum = {1'b0, shelf_offset} + {2'b0, shelf_height};
    stack_sat = stack_sum[P] ? {P{1'b1}} : stack_sum[P-1:0];

    // a fresh shelf or bin gets the rectangle laid flat when rotation is allowed
    swap2 = !fits && in_rot && (h1 > w1);
    w2 = swap2 ? h1 : w1;
    h2 = swap2 ? w1 : h1;

    if (fits) begin
      base_offset = shelf_offset;
      base_used   = shelf_used_width;
      base_height = shelf_height;
    end else begin
      base_offset = fits_above ? stack_sat : '0;
      base_used   = '0;
      base_height = '0;
    end

    if (!fits && !fits_above && (current_bin != {BIN_BITS{1'b1}})) begin
      current_bin_next = current_bin + 1'b1;
    end else begin
      current_bin_next = current_bin;
    end

    end_x = {1'b0, base_used} + {2'b0, w2};
    end_y = {1'b0, base_offset} + {2'b0, h2};

    shelf_offset_next     = base_offset;
    shelf_height_next     = (h2 > base_height) ? h2 : base_height;
    shelf_used_width_next = end_x[P] ? {P{1'b1}} : end_x[P-1:0];
    over_next = (end_x > {2'b0, bin_width}) || (end_y > {2'b0, bin_height});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width  <= BIN_SIZE_RESET;
      bin_height <= BIN_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BIN_WIDTH:  bin_width  <= cfg_data;
        REG_BIN_HEIGHT: bin_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      shelf_offset     <= '0;
      shelf_height     <= '0;
      shelf_used_width <= '0;
      current_bin      <= '0;
    end else begin
      if (in_take) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid        <= 1'b1;
        shelf_offset     <= shelf_offset_next;
        shelf_height     <= shelf_height_next;
        shelf_used_width <= shelf_used_width_next;
        current_bin      <= current_bin_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_w   <= s_tdata[S-1:0];
      in_h   <= s_tdata[2*S-1:S];
      in_rot <= s_tdata[2*S];
    end
    if (advance) begin
      out_x    <= base_used;
      out_y    <= base_offset;
      out_bin  <= current_bin_next;
      out_rot  <= swap1 ^ swap2;
      out_over <= over_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                     out_over, out_rot, out_bin, out_y, out_x};

  // a held result always matches the shelf state it left behind
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_bin == current_bin) && (out_y == shelf_offset))
    else $error("result bin or offset differs from shelf state");

  // a new bin restarts at the bottom with an empty shelf
  assert property (@(posedge clk) disable iff (rst)
    (!rst && advance && !fits && !fits_above) |=>
      (shelf_offset == '0) && (out_x == '0))
    else $error("new bin did not restart at the origin");

  // bin count never goes backwards
  assert property (@(posedge clk) disable iff (rst)
    (!rst && advance) |=> (current_bin >= $past(current_bin)))
    else $error("bin count decreased");

endmodule
